// ----- src/uurp_pkg.sv -----
// Shared types, constants and character helpers for the request path parser.
`timescale 1ns / 1ps
`default_nettype none

package uurp_pkg;

    localparam int CharWidth   = 8;
    localparam int KindWidth   = 2;
    localparam int FirstWidth  = 16;
    localparam int SecondWidth = 32;
    localparam int PosWidth    = 4;
    localparam int AmpWidth    = 2;

    localparam logic [KindWidth-1:0] KIND_INVALID = 2'd0;
    localparam logic [KindWidth-1:0] KIND_BEGIN   = 2'd1;
    localparam logic [KindWidth-1:0] KIND_WRITE   = 2'd2;
    localparam logic [KindWidth-1:0] KIND_END     = 2'd3;

    localparam logic [PosWidth-1:0] POS_MAX     = 4'd15;
    localparam logic [PosWidth-1:0] POS_PREFIX  = 4'd5;
    localparam logic [PosWidth-1:0] POS_END_LEN = 4'd4;
    localparam logic [PosWidth-1:0] POS_MIN_LEN = 4'd8;

    localparam logic [AmpWidth-1:0] AMP_MAX    = 2'd3;
    localparam logic [AmpWidth-1:0] AMP_FIRST  = 2'd1;
    localparam logic [AmpWidth-1:0] AMP_SECOND = 2'd2;

    localparam logic [CharWidth-1:0] CH_AMP   = 8'h26;
    localparam logic [CharWidth-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CharWidth-1:0] CH_MINUS = 8'h2D;
    localparam logic [CharWidth-1:0] CH_SLASH = 8'h2F;
    localparam logic [CharWidth-1:0] CH_U     = 8'h75;
    localparam logic [CharWidth-1:0] CH_P     = 8'h70;
    localparam logic [CharWidth-1:0] CH_B     = 8'h62;
    localparam logic [CharWidth-1:0] CH_W     = 8'h77;
    localparam logic [CharWidth-1:0] CH_E     = 8'h65;
    localparam logic [CharWidth-1:0] CH_SPACE = 8'h20;
    localparam logic [CharWidth-1:0] CH_TAB   = 8'h09;
    localparam logic [CharWidth-1:0] CH_CR    = 8'h0D;
    localparam logic [CharWidth-1:0] CH_ZERO  = 8'h30;
    localparam logic [CharWidth-1:0] CH_NINE  = 8'h39;

    typedef struct packed {
        logic [CharWidth-1:0] char_byte;
        logic                 last_char;
    } char_item_t;

    typedef struct packed {
        logic [KindWidth-1:0]   request_kind;
        logic [FirstWidth-1:0]  first_value;
        logic [SecondWidth-1:0] second_value;
    } result_t;

    typedef enum logic [2:0] {
        PH_SKIP   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_STOP   = 3'b100
    } phase_t;

    function automatic logic [CharWidth-1:0] begin_char(input logic [2:0] idx);
        logic [CharWidth-1:0] ch;
        unique case (idx)
            3'd0:    ch = CH_SLASH;
            3'd1:    ch = CH_U;
            3'd2:    ch = CH_P;
            3'd3:    ch = CH_B;
            3'd4:    ch = CH_AMP;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CharWidth-1:0] write_char(input logic [2:0] idx);
        logic [CharWidth-1:0] ch;
        unique case (idx)
            3'd0:    ch = CH_SLASH;
            3'd1:    ch = CH_U;
            3'd2:    ch = CH_P;
            3'd3:    ch = CH_W;
            3'd4:    ch = CH_AMP;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [CharWidth-1:0] end_char(input logic [1:0] idx);
        logic [CharWidth-1:0] ch;
        unique case (idx)
            2'd0:    ch = CH_SLASH;
            2'd1:    ch = CH_U;
            2'd2:    ch = CH_P;
            default: ch = CH_E;
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [CharWidth-1:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [CharWidth-1:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

endpackage

`default_nettype wire

// ----- src/uurp_in_stage.sv -----
// Input register for incoming path characters.
`timescale 1ns / 1ps
`default_nettype none

module uurp_in_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [uurp_pkg::CharWidth-1:0] s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          advance,
    output logic                               item_valid,
    output uurp_pkg::char_item_t               item
);

    logic                 valid_reg;
    logic                 valid_next;
    uurp_pkg::char_item_t item_reg;
    logic                 accept;

    assign s_axis_tready = !valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.char_byte <= s_axis_tdata;
            item_reg.last_char <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- src/uurp_parse.sv -----
// Path parsing state and per-character update with result evaluation.
`timescale 1ns / 1ps
`default_nettype none

module uurp_parse (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire uurp_pkg::char_item_t item,
    output uurp_pkg::result_t         result
);

    logic [uurp_pkg::PosWidth-1:0]    pos_reg,    pos_next;
    logic [2:0]                       alive_reg,  alive_next;
    logic [uurp_pkg::KindWidth-1:0]   kind_reg,   kind_next;
    logic [uurp_pkg::AmpWidth-1:0]    amp_reg,    amp_next;
    uurp_pkg::phase_t                 phase_reg,  phase_next;
    logic                             neg_reg,    neg_next;
    logic [uurp_pkg::FirstWidth-1:0]  first_reg,  first_next;
    logic [uurp_pkg::SecondWidth-1:0] second_reg, second_next;

    logic [uurp_pkg::CharWidth-1:0]   c;
    logic [uurp_pkg::FirstWidth-1:0]  first_digit;
    logic [uurp_pkg::SecondWidth-1:0] second_digit;

    assign c            = item.char_byte;
    assign first_digit  = {{(uurp_pkg::FirstWidth-4){1'b0}}, c[3:0]};
    assign second_digit = {{(uurp_pkg::SecondWidth-4){1'b0}}, c[3:0]};

    always_comb begin
        pos_next    = (pos_reg == uurp_pkg::POS_MAX) ? pos_reg : pos_reg + 4'd1;
        alive_next  = alive_reg;
        kind_next   = kind_reg;
        amp_next    = amp_reg;
        phase_next  = phase_reg;
        neg_next    = neg_reg;
        first_next  = first_reg;
        second_next = second_reg;

        if (pos_reg < uurp_pkg::POS_PREFIX) begin
            if (c != uurp_pkg::begin_char(pos_reg[2:0])) begin
                alive_next[0] = 1'b0;
            end
            if (c != uurp_pkg::write_char(pos_reg[2:0])) begin
                alive_next[1] = 1'b0;
            end
        end
        if (pos_reg < uurp_pkg::POS_END_LEN) begin
            if (c != uurp_pkg::end_char(pos_reg[1:0])) begin
                alive_next[2] = 1'b0;
            end
        end else begin
            alive_next[2] = 1'b0;
        end
        if (pos_reg == uurp_pkg::POS_END_LEN) begin
            if (alive_next[0]) begin
                kind_next = uurp_pkg::KIND_BEGIN;
            end else if (alive_next[1]) begin
                kind_next = uurp_pkg::KIND_WRITE;
            end
        end

        if (c == uurp_pkg::CH_AMP) begin
            if ((amp_reg == uurp_pkg::AMP_FIRST) && neg_reg) begin
                first_next = 16'd0 - first_reg;
            end
            if (amp_reg != uurp_pkg::AMP_MAX) begin
                amp_next = amp_reg + 2'd1;
            end
            phase_next = uurp_pkg::PH_SKIP;
            neg_next   = 1'b0;
        end else if ((amp_reg == uurp_pkg::AMP_FIRST) || (amp_reg == uurp_pkg::AMP_SECOND)) begin
            priority if ((phase_reg == uurp_pkg::PH_SKIP) && uurp_pkg::is_space(c)) begin
                phase_next = phase_reg;
            end else if ((phase_reg == uurp_pkg::PH_SKIP) &&
                         ((c == uurp_pkg::CH_PLUS) || (c == uurp_pkg::CH_MINUS))) begin
                neg_next   = (c == uurp_pkg::CH_MINUS);
                phase_next = uurp_pkg::PH_DIGITS;
            end else if ((phase_reg != uurp_pkg::PH_STOP) && uurp_pkg::is_digit(c)) begin
                phase_next = uurp_pkg::PH_DIGITS;
                if (amp_reg == uurp_pkg::AMP_FIRST) begin
                    first_next = {first_reg[12:0], 3'b000} + {first_reg[14:0], 1'b0}
                               + first_digit;
                end else begin
                    second_next = {second_reg[28:0], 3'b000} + {second_reg[30:0], 1'b0}
                                + second_digit;
                end
            end else begin
                phase_next = uurp_pkg::PH_STOP;
            end
        end
    end

    always_comb begin
        result.request_kind = uurp_pkg::KIND_INVALID;
        result.first_value  = '0;
        result.second_value = '0;
        if (alive_next[2] && (pos_next == uurp_pkg::POS_END_LEN)) begin
            result.request_kind = uurp_pkg::KIND_END;
        end else if ((kind_next != uurp_pkg::KIND_INVALID) &&
                     (pos_next >= uurp_pkg::POS_MIN_LEN) &&
                     (amp_next == uurp_pkg::AMP_SECOND)) begin
            result.request_kind = kind_next;
            result.first_value  = first_next;
            result.second_value = neg_next ? (32'd0 - second_next) : second_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (step && item.last_char)) begin
            pos_reg    <= '0;
            alive_reg  <= 3'b111;
            kind_reg   <= uurp_pkg::KIND_INVALID;
            amp_reg    <= '0;
            phase_reg  <= uurp_pkg::PH_SKIP;
            neg_reg    <= 1'b0;
            first_reg  <= '0;
            second_reg <= '0;
        end else if (step) begin
            pos_reg    <= pos_next;
            alive_reg  <= alive_next;
            kind_reg   <= kind_next;
            amp_reg    <= amp_next;
            phase_reg  <= phase_next;
            neg_reg    <= neg_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/update_request_uri_parser.sv -----
// Top level of the update request path parser with its result register.
//
// Usage: path characters arrive on the s_axis channel, one per transfer, the
// character in s_axis_tdata[7:0] and s_axis_tlast high on the final one. On
// that final character one result transfer leaves on m_axis: the request
// kind (invalid, begin, write, end) in m_axis_tuser and the two decimal
// numbers in m_axis_tdata. Other characters give no result.
// Path: a final character is registered in the input stage and, once it advances,
// loads the result register that drives m_axis_tvalid.
// Throughput: one character per cycle unless a result waits on m_axis; each
// character is a small compare-and-accumulate step into the state registers.
// Reset: aresetn low for one edge clears both valid flags and the parser
// state; the next character starts a new path.
// Stall: while m_axis_tready is low with a result pending, the input
// register holds one character and s_axis_tready drops once it is full;
// no character or result is dropped.
`timescale 1ns / 1ps
`default_nettype none

module update_request_uri_parser (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_byte
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,  // [15:0] first_value, [47:16] second_value
    output logic [1:0]       m_axis_tuser   // [1:0] request_kind
);

    logic                 item_valid;
    uurp_pkg::char_item_t item;
    logic                 advance;
    uurp_pkg::result_t    result;
    uurp_pkg::result_t    out_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 load;

    assign advance = item_valid && (!out_valid_reg || m_axis_tready);
    assign load    = advance && item.last_char;

    uurp_in_stage u_in_stage (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    uurp_parse u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item),
        .result  (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        if (load) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.second_value, out_reg.first_value};
    assign m_axis_tuser  = out_reg.request_kind;

endmodule

`default_nettype wire
